// ===== hdl/jac_pkg.sv =====
// Shared types, constants and helper functions of the J1939 address-claim node.
`default_nettype none

package jac_pkg;

  localparam int NAME_BYTES      = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  NULL_ADDR    = 8'd254;
  localparam logic [7:0]  GLOBAL_ADDR  = 8'd255;
  localparam logic [7:0]  PF_CLAIM     = 8'hEE;
  localparam logic [7:0]  PF_REQUEST   = 8'hEA;
  localparam logic [2:0]  CLAIM_PRIO   = 3'd6;
  localparam logic [23:0] CLAIM_PGN    = 24'h00EE00;
  localparam logic [3:0]  FULL_DLC     = 4'd8;
  localparam logic [3:0]  REQ_MIN_DLC  = 4'd3;

  localparam logic [63:0] CA_NAME_RST    = 64'd0;
  localparam logic [7:0]  PREF_ADDR_RST  = 8'd128;
  localparam logic [15:0] WAIT_TICKS_RST = 16'd250;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_RX    = 2'd2,
    FUNC_PUT   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_BUS  = 2'd1,
    DEST_APP  = 2'd2
  } dest_t;

  typedef enum logic [1:0] {
    RX_REQUEST = 2'd0,
    RX_CLAIM   = 2'd1,
    RX_OTHER   = 2'd2
  } rx_kind_t;

  typedef enum logic [1:0] {
    REG_CA_NAME    = 2'd0,
    REG_PREF_ADDR  = 2'd1,
    REG_WAIT_TICKS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] ca_name;
    logic [7:0]  pref_addr;
    logic [15:0] wait_ticks;
  } jac_cfg_t;

  typedef struct packed {
    func_t       func;
    rx_kind_t    rx_kind;
    logic        ps_global;
    logic        req_match;
    logic        sa_pref;
    logic        name_lower;
    logic [28:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
  } jac_item_t;

  function automatic logic [28:0] claim_id(input logic [7:0] sa);
    claim_id = {CLAIM_PRIO, 2'b00, PF_CLAIM, GLOBAL_ADDR, sa};
  endfunction

  function automatic logic [63:0] byte_rev(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      r[(NAME_BYTES - 1 - i) * 8 +: 8] = x[i * 8 +: 8];
    end
    byte_rev = r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jac_front.sv =====
// Front end: decodes and classifies each input item before it enters the queue.
`default_nettype none

module jac_front (
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_func,
  input  wire logic [28:0]       in_frame_id,
  input  wire logic [3:0]        in_frame_dlc,
  input  wire logic [63:0]       in_frame_data,
  input  wire jac_pkg::jac_cfg_t cfg,
  input  wire logic              q_full,
  output logic                   in_stall,
  output logic                   push,
  output jac_pkg::jac_item_t     item
);
  import jac_pkg::*;

  logic [3:0]  dlc_c;
  logic [63:0] data_m;
  logic [7:0]  pf;
  logic [7:0]  ps;
  logic [7:0]  sa;

  assign dlc_c = (in_frame_dlc > FULL_DLC) ? FULL_DLC : in_frame_dlc;
  assign pf    = in_frame_id[23:16];
  assign ps    = in_frame_id[15:8];
  assign sa    = in_frame_id[7:0];

  always_comb begin
    data_m = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (4'(i) < dlc_c) begin
        data_m[i * 8 +: 8] = in_frame_data[i * 8 +: 8];
      end
    end
  end

  always_comb begin
    item.func = func_t'(in_func);
    if (pf == PF_REQUEST) begin
      item.rx_kind = RX_REQUEST;
    end else if (pf == PF_CLAIM) begin
      item.rx_kind = RX_CLAIM;
    end else begin
      item.rx_kind = RX_OTHER;
    end
    item.ps_global  = (ps == GLOBAL_ADDR);
    item.req_match  = (dlc_c >= REQ_MIN_DLC) && (data_m[23:0] == CLAIM_PGN);
    item.sa_pref    = (sa == cfg.pref_addr);
    item.name_lower = (byte_rev(cfg.ca_name) < byte_rev(data_m));
    item.id         = in_frame_id;
    item.dlc        = dlc_c;
    item.data       = data_m;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== hdl/jac_queue.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none

module jac_queue #(
  parameter int DEPTH = jac_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire jac_pkg::jac_item_t push_item,
  input  wire logic               pop,
  output logic                    full,
  output logic                    head_valid,
  output jac_pkg::jac_item_t      head_item
);
  import jac_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jac_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue read while empty");
  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r + 1'b1 == $past(count_r)))
    else $error("queue count did not drop after a read");
`endif

endmodule

`default_nettype wire

// ===== hdl/jac_back.sv =====
// Back end: applies each item to the claim state and registers its result.
`default_nettype none

module jac_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jac_pkg::jac_cfg_t  cfg,
  input  wire logic               head_valid,
  input  wire jac_pkg::jac_item_t head_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_dest,
  output logic [28:0]             out_id,
  output logic [3:0]              out_dlc,
  output logic [63:0]             out_data,
  output logic                    out_put_accepted,
  output logic [7:0]              out_own_address
);
  import jac_pkg::*;

  logic [7:0]  held_r, held_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] wait_r, wait_nxt;

  logic        out_valid_r;
  dest_t       dest_r, dest_nxt;
  logic [28:0] id_r, id_nxt;
  logic [3:0]  dlc_r, dlc_nxt;
  logic [63:0] data_r, data_nxt;
  logic        put_r, put_nxt;
  logic [7:0]  own_r;
  logic        for_us;

  assign pop    = head_valid && (!out_valid_r || !out_stall);
  assign for_us = head_item.ps_global ||
                  ((head_item.id[15:8] == held_r) && (held_r != NULL_ADDR));

  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    wait_nxt = wait_r;
    dest_nxt = DEST_NONE;
    id_nxt   = '0;
    dlc_nxt  = '0;
    data_nxt = '0;
    put_nxt  = 1'b0;
    case (head_item.func)
      FUNC_START: begin
        dest_nxt = DEST_BUS;
        id_nxt   = claim_id(cfg.pref_addr);
        dlc_nxt  = FULL_DLC;
        data_nxt = cfg.ca_name;
        pend_nxt = 1'b1;
        wait_nxt = cfg.wait_ticks;
      end
      FUNC_TICK: begin
        if (pend_r) begin
          if (wait_r <= 16'd1) begin
            wait_nxt = '0;
            pend_nxt = 1'b0;
            held_nxt = cfg.pref_addr;
          end else begin
            wait_nxt = wait_r - 1'b1;
          end
        end else begin
          wait_nxt = '0;
        end
      end
      FUNC_RX: begin
        if (for_us) begin
          case (head_item.rx_kind)
            RX_REQUEST: begin
              if (head_item.req_match) begin
                dest_nxt = DEST_BUS;
                id_nxt   = claim_id(cfg.pref_addr);
                dlc_nxt  = FULL_DLC;
                data_nxt = cfg.ca_name;
              end
            end
            RX_CLAIM: begin
              if (head_item.sa_pref) begin
                dest_nxt = DEST_BUS;
                dlc_nxt  = FULL_DLC;
                data_nxt = cfg.ca_name;
                if (head_item.name_lower) begin
                  id_nxt   = claim_id(cfg.pref_addr);
                  pend_nxt = 1'b1;
                  wait_nxt = cfg.wait_ticks;
                end else begin
                  id_nxt   = claim_id(NULL_ADDR);
                  held_nxt = NULL_ADDR;
                  pend_nxt = 1'b0;
                  wait_nxt = '0;
                end
              end
            end
            default: begin
              dest_nxt = DEST_APP;
              id_nxt   = head_item.id;
              dlc_nxt  = head_item.dlc;
              data_nxt = head_item.data;
            end
          endcase
        end
      end
      default: begin
        if (!pend_r) begin
          dest_nxt = DEST_BUS;
          id_nxt   = {head_item.id[28:8], held_r};
          dlc_nxt  = head_item.dlc;
          data_nxt = head_item.data;
          put_nxt  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= NULL_ADDR;
      pend_r      <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        held_r <= held_nxt;
        pend_r <= pend_nxt;
        wait_r <= wait_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dest_r <= dest_nxt;
      id_r   <= id_nxt;
      dlc_r  <= dlc_nxt;
      data_r <= data_nxt;
      put_r  <= put_nxt;
      own_r  <= held_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest         = dest_r;
  assign out_id           = id_r;
  assign out_dlc          = dlc_r;
  assign out_data         = data_r;
  assign out_put_accepted = put_r;
  assign out_own_address  = own_r;

`ifndef ASSERT_OFF
  a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> (wait_r == '0)) else $error("wait counter running with no claim pending");
  a_put_to_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && put_r) |-> (dest_r == DEST_BUS))
    else $error("accepted application item not routed to the bus");
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r) else $error("taken item produced no result");
`endif

endmodule

`default_nettype wire

// ===== hdl/j1939_address_claim_node.sv =====
// Top level of the J1939 address-claim node: configuration registers and the datapath.
`default_nettype none

// Each item (start claim, timer tick, received frame or application frame)
// yields exactly one result item. The block takes one item per clock cycle
// while in_stall is low: the front end classifies the item in its accept
// cycle and writes it into a QUEUE_DEPTH-entry queue, and the back end,
// unless out_stall holds its output, applies one queued item per cycle to
// the claim state and registers its result. An item waits in a queue entry
// and its result in the back end's output register. The back end's state
// update sets the rate. Configuration registers sit at byte addresses 0
// (ca_name, 64 bits), 8 (preferred_address) and 16 (claim_wait_ticks) of
// the 64-bit APB port; write them only while the block holds no item.
module j1939_address_claim_node #(
  parameter int QUEUE_DEPTH = jac_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [jac_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [jac_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [jac_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [28:0]                in_frame_id,
  input  wire logic [3:0]                 in_frame_dlc,
  input  wire logic [63:0]                in_frame_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_dest,
  output logic [28:0]                     out_id,
  output logic [3:0]                      out_dlc,
  output logic [63:0]                     out_data,
  output logic                            out_put_accepted,
  output logic [7:0]                      out_own_address
);
  import jac_pkg::*;

  logic [63:0] ca_name_r;
  logic [7:0]  pref_addr_r;
  logic [15:0] wait_ticks_r;
  jac_cfg_t    cfg;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  jac_item_t push_item;
  jac_item_t head_item;

  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_name_r    <= CA_NAME_RST;
      pref_addr_r  <= PREF_ADDR_RST;
      wait_ticks_r <= WAIT_TICKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CA_NAME:    ca_name_r    <= cfg_pwdata;
        REG_PREF_ADDR:  pref_addr_r  <= cfg_pwdata[7:0];
        REG_WAIT_TICKS: wait_ticks_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CA_NAME:    cfg_prdata = ca_name_r;
      REG_PREF_ADDR:  cfg_prdata = {56'd0, pref_addr_r};
      REG_WAIT_TICKS: cfg_prdata = {48'd0, wait_ticks_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.ca_name    = ca_name_r;
  assign cfg.pref_addr  = pref_addr_r;
  assign cfg.wait_ticks = wait_ticks_r;

  jac_front u_front (
    .in_valid      (in_valid),
    .in_func       (in_func),
    .in_frame_id   (in_frame_id),
    .in_frame_dlc  (in_frame_dlc),
    .in_frame_data (in_frame_data),
    .cfg           (cfg),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .item          (push_item)
  );

  jac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  jac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dest         (out_dest),
    .out_id           (out_id),
    .out_dlc          (out_dlc),
    .out_data         (out_data),
    .out_put_accepted (out_put_accepted),
    .out_own_address  (out_own_address)
  );

endmodule

`default_nettype wire
